[hw/rtl/stereo_tremolo_lfo_assert.svh]
`ifndef STEREO_TREMOLO_LFO_ASSERT_SVH
`define STEREO_TREMOLO_LFO_ASSERT_SVH
// Assertion macros for the stereo tremolo block.
// STL_ASSERT_CLK names the clock and the reset explicitly.
`define STL_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stereo tremolo assertion failed");
// STL_ASSERT uses the block's own clock and reset names.
`define STL_ASSERT(label, prop) `STL_ASSERT_CLK(label, clock, reset, prop)
`endif

[hw/rtl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo tremolo package
// Shared types, constants, sequencer codes and the sine table generator.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int SAMPLE_BITS      = 24;
   localparam int DEF_PHASE_BITS   = 24;
   localparam int DEF_SINE_DEPTH   = 256;
   localparam int Q15_BITS         = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;
   localparam int MUL_B_BITS       = 17;

   localparam logic [Q15_BITS-1:0] Q15_ONE = 16'd32768;

   localparam logic [Q15_BITS-1:0]      RST_INPUT_GAIN = 16'd32768;
   localparam logic [Q15_BITS-1:0]      RST_MOD_DEPTH  = 16'd0;
   localparam logic [CSR_DATA_BITS-1:0] RST_PHASE_STEP = 16'd1398;
   localparam logic [Q15_BITS-1:0]      RST_WAVE_SHAPE = 16'd0;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INPUT_GAIN = 2'd0,
      CSR_MOD_DEPTH  = 2'd1,
      CSR_PHASE_STEP = 2'd2,
      CSR_WAVE_SHAPE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic [Q15_BITS-1:0]           mod_gain;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_IDX,
      ST_MUL_GL,
      ST_GR_ROM,
      ST_MUL_LFO,
      ST_LOAD_GR,
      ST_MUL_DEP,
      ST_WAIT_DEP,
      ST_MUL_OL,
      ST_MUL_OR,
      ST_OUT_L,
      ST_OUT_R
   } state_type;

   typedef enum logic [2:0] {
      MSEL_IDX,
      MSEL_GL,
      MSEL_GR,
      MSEL_LFO,
      MSEL_DEP,
      MSEL_OL,
      MSEL_OR
   } mul_sel_type;

   typedef struct packed {
      logic        idle;
      logic        mul_issue;
      mul_sel_type mul_sel;
      logic        load_sine;
      logic        load_gl;
      logic        load_gr;
      logic        load_gain;
      logic        load_left;
      logic        load_rsp;
   } ctrl_type;

   // Saturates a register value to Q1.15 unity.
   function automatic logic [Q15_BITS-1:0] clamp_q15(input logic [Q15_BITS-1:0] v);
      return (v > Q15_ONE) ? Q15_ONE : v;
   endfunction

   // Degree-9 Taylor sine in Q30, each Horner step truncated, rounded to Q15.
   function automatic logic [Q15_BITS-1:0] sine_q15(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32768) begin
         v = 64'd32768;
      end
      return v[Q15_BITS-1:0];
   endfunction

endpackage

[hw/rtl/stereo_tremolo_lfo.sv]
// ----------------------------------------------------------------------------
// Stereo tremolo with blended sine/square LFO
// Input gain, LFO phase accumulator, quarter-wave sine, tremolo gain and
// output saturation; every product goes through one shared multiplier.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  req_data  (left_in, right_in)
//   rsp_     out        rsp_valid / rsp_ready  rsp_data  (left_out, right_out, mod_gain)
//   csr_     in         csr_write_en           csr_index, csr_wdata
//
// The result register is loaded at the end of eleven sequencer steps after
// the transfer, around the two-stage shared multiplier; the sequencer then
// returns to idle, and only there takes a new transfer. The seven multiplier
// issues per sample and the multiplier's latency set the step count.
// Reset is synchronous and restores the register defaults and the phase. A waiting
// result does not block the next transfer; a second finished result stalls in
// the last step until the first is taken.
//
module stereo_tremolo_lfo #(
   parameter int PHASE_BITS       = stl_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_DEPTH = stl_pkg::DEF_SINE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  stl_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output stl_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [stl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [stl_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int SB = stl_pkg::SAMPLE_BITS;
   localparam int QB = stl_pkg::Q15_BITS;
   // The multiplier's A side must hold a full sample or a quadrant offset.
   localparam int AW = (SB > PHASE_BITS) ? SB : PHASE_BITS;
   localparam int BW = stl_pkg::MUL_B_BITS;
   localparam int PW = AW + BW;
   localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [PHASE_BITS-2:0] QUAD_LEN = (PHASE_BITS-1)'(1) << (PHASE_BITS - 2);
   localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] SAT_LO = PW'(-(64'sd1 <<< (SB - 1)));
   localparam logic signed [PW-1:0] HALF_LSB = PW'(16384);

   // Configuration registers.
   logic [QB-1:0]                     input_gain_ff;
   logic [QB-1:0]                     mod_depth_ff;
   logic [stl_pkg::CSR_DATA_BITS-1:0] phase_step_ff;
   logic [QB-1:0]                     wave_shape_ff;

   // Per-sample state.
   logic [PHASE_BITS-1:0]    phase_ff;
   logic signed [SB-1:0]     left_ff;
   logic signed [SB-1:0]     right_ff;
   logic signed [SB-1:0]     gl_ff;
   logic signed [SB-1:0]     gr_ff;
   logic [QB-1:0]            gain_ff;
   logic signed [SB-1:0]     left_sat_ff;
   logic                     rsp_valid_ff;
   stl_pkg::rsp_type         rsp_data_ff;

   stl_pkg::ctrl_type        ctrl;
   logic                     req_fire;
   logic                     out_free;

   logic signed [AW-1:0]     mul_a;
   logic signed [BW-1:0]     mul_b;
   logic signed [PW-1:0]     mul_prod;
   logic signed [PW-1:0]     prod_rnd;
   logic signed [SB-1:0]     prod_sat;

   logic [QB-1:0]            gain_in;
   logic [QB-1:0]            depth_in;
   logic [QB-1:0]            shape_in;
   logic [QB-1:0]            shape_inv;

   logic [1:0]               quad;
   logic [PHASE_BITS-2:0]    quad_pos;
   logic [IW-1:0]            rom_addr;
   logic [QB-1:0]            sine_mag;
   logic [QB:0]              sine_sum;
   logic [QB-1:0]            sine_lfo;
   logic [31:0]              lfo_sum;
   logic [QB-1:0]            lfo_now;
   logic [31:0]              depth_sum;
   logic [QB:0]              gain_sum;
   logic [QB-1:0]            gain_now;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = ctrl.idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   stl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   stl_mul #(
      .A_BITS (AW),
      .B_BITS (BW)
   ) u_mul (
      .clock (clock),
      .issue (ctrl.mul_issue),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   stl_sine_rom #(
      .DEPTH     (SINE_TABLE_DEPTH),
      .ADDR_BITS (IW)
   ) u_sine_rom (
      .clock (clock),
      .rd_en (ctrl.load_sine),
      .addr  (rom_addr),
      .data  (sine_mag)
   );

   // Register values above unity act as unity.
   assign gain_in   = stl_pkg::clamp_q15(input_gain_ff);
   assign depth_in  = stl_pkg::clamp_q15(mod_depth_ff);
   assign shape_in  = stl_pkg::clamp_q15(wave_shape_ff);
   assign shape_inv = stl_pkg::Q15_ONE - shape_in;

   // The top two phase bits pick the quadrant; odd quadrants run backwards.
   assign quad     = phase_ff[PHASE_BITS-1 -: 2];
   assign quad_pos = quad[0] ? (QUAD_LEN - {1'b0, phase_ff[PHASE_BITS-3:0]})
                             : {1'b0, phase_ff[PHASE_BITS-3:0]};

   // Table index is floor(pos * depth / quadrant length); it never exceeds depth.
   assign rom_addr = mul_prod[PHASE_BITS-2 +: IW];

   // Negative half of the turn flips the table value around one half.
   assign sine_sum = quad[1] ? ((QB+1)'(stl_pkg::Q15_ONE) - (QB+1)'(sine_mag))
                             : ((QB+1)'(stl_pkg::Q15_ONE) + (QB+1)'(sine_mag));
   assign sine_lfo = sine_sum[QB:1];

   // The square wave is unity in the first half turn, so its share is a shift.
   assign lfo_sum = mul_prod[31:0]
                  + (phase_ff[PHASE_BITS-1] ? 32'd0 : (32'(shape_in) << 15))
                  + 32'd16384;
   assign lfo_now = lfo_sum[15 +: QB];

   assign depth_sum = mul_prod[31:0] + 32'd16384;
   assign gain_sum  = (QB+1)'(stl_pkg::Q15_ONE - depth_in) + depth_sum[15 +: QB+1];
   assign gain_now  = (gain_sum > (QB+1)'(stl_pkg::Q15_ONE)) ? stl_pkg::Q15_ONE
                                                             : gain_sum[QB-1:0];

   // Round half up after a Q15 product, then clip to the sample range.
   assign prod_rnd = (mul_prod + HALF_LSB) >>> 15;
   always_comb begin
      if (prod_rnd > SAT_HI) begin
         prod_sat = SAT_HI[SB-1:0];
      end else if (prod_rnd < SAT_LO) begin
         prod_sat = SAT_LO[SB-1:0];
      end else begin
         prod_sat = prod_rnd[SB-1:0];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.mul_sel)
         stl_pkg::MSEL_IDX: begin
            mul_a = AW'(quad_pos);
            mul_b = BW'(SINE_TABLE_DEPTH);
         end
         stl_pkg::MSEL_GL: begin
            mul_a = AW'(left_ff);
            mul_b = BW'(gain_in);
         end
         stl_pkg::MSEL_GR: begin
            mul_a = AW'(right_ff);
            mul_b = BW'(gain_in);
         end
         stl_pkg::MSEL_LFO: begin
            mul_a = AW'(sine_lfo);
            mul_b = BW'(shape_inv);
         end
         stl_pkg::MSEL_DEP: begin
            mul_a = AW'(lfo_now);
            mul_b = BW'(depth_in);
         end
         stl_pkg::MSEL_OL: begin
            mul_a = AW'(gl_ff);
            mul_b = BW'(gain_now);
         end
         stl_pkg::MSEL_OR: begin
            mul_a = AW'(gr_ff);
            mul_b = BW'(gain_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Configuration writes; indexes beyond the list have no effect.
   always_ff @(posedge clock) begin
      if (reset) begin
         input_gain_ff <= stl_pkg::RST_INPUT_GAIN;
         mod_depth_ff  <= stl_pkg::RST_MOD_DEPTH;
         phase_step_ff <= stl_pkg::RST_PHASE_STEP;
         wave_shape_ff <= stl_pkg::RST_WAVE_SHAPE;
      end else if (csr_write_en) begin
         case (csr_index)
            stl_pkg::CSR_INPUT_GAIN: input_gain_ff <= csr_wdata;
            stl_pkg::CSR_MOD_DEPTH:  mod_depth_ff  <= csr_wdata;
            stl_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            stl_pkg::CSR_WAVE_SHAPE: wave_shape_ff <= csr_wdata;
            default: begin
               input_gain_ff <= input_gain_ff;
            end
         endcase
      end
   end

   // The phase advances at the transfer, so the new phase serves this sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_ff + PHASE_BITS'(phase_step_ff);
      end
   end

   // Datapath holding registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff  <= req_data.left_in;
         right_ff <= req_data.right_in;
      end
      if (ctrl.load_gl) begin
         gl_ff <= prod_rnd[SB-1:0];
      end
      if (ctrl.load_gr) begin
         gr_ff <= prod_rnd[SB-1:0];
      end
      if (ctrl.load_gain) begin
         gain_ff <= gain_now;
      end
      if (ctrl.load_left) begin
         left_sat_ff <= prod_sat;
      end
      if (ctrl.load_rsp) begin
         rsp_data_ff.left_out  <= left_sat_ff;
         rsp_data_ff.right_out <= prod_sat;
         rsp_data_ff.mod_gain  <= gain_ff;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

[hw/rtl/stl_mul.sv]
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with registered operands and a registered product.
// ----------------------------------------------------------------------------
module stl_mul #(
   parameter int A_BITS = 24,
   parameter int B_BITS = 17
) (
   input  logic                             clock,
   input  logic                             issue,
   input  logic signed [A_BITS-1:0]         op_a,
   input  logic signed [B_BITS-1:0]         op_b,
   output logic signed [A_BITS+B_BITS-1:0]  prod
);

   logic signed [A_BITS-1:0]        a_ff;
   logic signed [B_BITS-1:0]        b_ff;
   logic signed [A_BITS+B_BITS-1:0] prod_ff;

   // Operands hold between issues, so the product stays put while idle.
   always_ff @(posedge clock) begin
      if (issue) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      prod_ff <= (A_BITS+B_BITS)'(a_ff) * (A_BITS+B_BITS)'(b_ff);
   end

   assign prod = prod_ff;

endmodule

[hw/rtl/stl_sine_rom.sv]
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant Q1.15 table of DEPTH+1 entries with a registered read port.
// ----------------------------------------------------------------------------
module stl_sine_rom #(
   parameter int DEPTH = stl_pkg::DEF_SINE_DEPTH,
   parameter int ADDR_BITS = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [ADDR_BITS-1:0]          addr,
   output logic [stl_pkg::Q15_BITS-1:0]  data
);

   logic [stl_pkg::Q15_BITS-1:0] rom [DEPTH+1];
   logic [stl_pkg::Q15_BITS-1:0] data_ff;

   for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
      localparam logic [63:0] ANGLE = (64'(k) * stl_pkg::HALF_PI_Q30) / 64'(DEPTH);
      assign rom[k] = stl_pkg::sine_q15(ANGLE);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom[addr];
      end
   end

   assign data = data_ff;

endmodule

[hw/rtl/stl_ctrl.sv]
// ----------------------------------------------------------------------------
// Tremolo sequencer
// Steps one sample pair through the shared multiplier and the sine table.
// ----------------------------------------------------------------------------
module stl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              out_free,
   output stl_pkg::ctrl_type ctrl
);

   stl_pkg::state_type state_ff;
   stl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stl_pkg::ST_IDLE:     if (req_fire) state_in = stl_pkg::ST_MUL_IDX;
         stl_pkg::ST_MUL_IDX:  state_in = stl_pkg::ST_MUL_GL;
         stl_pkg::ST_MUL_GL:   state_in = stl_pkg::ST_GR_ROM;
         stl_pkg::ST_GR_ROM:   state_in = stl_pkg::ST_MUL_LFO;
         stl_pkg::ST_MUL_LFO:  state_in = stl_pkg::ST_LOAD_GR;
         stl_pkg::ST_LOAD_GR:  state_in = stl_pkg::ST_MUL_DEP;
         stl_pkg::ST_MUL_DEP:  state_in = stl_pkg::ST_WAIT_DEP;
         stl_pkg::ST_WAIT_DEP: state_in = stl_pkg::ST_MUL_OL;
         stl_pkg::ST_MUL_OL:   state_in = stl_pkg::ST_MUL_OR;
         stl_pkg::ST_MUL_OR:   state_in = stl_pkg::ST_OUT_L;
         stl_pkg::ST_OUT_L:    state_in = stl_pkg::ST_OUT_R;
         stl_pkg::ST_OUT_R:    if (out_free) state_in = stl_pkg::ST_IDLE;
         default:              state_in = stl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = stl_pkg::MSEL_IDX;
      case (state_ff)
         stl_pkg::ST_IDLE: begin
            ctrl.idle = 1'b1;
         end
         stl_pkg::ST_MUL_IDX: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_IDX;
         end
         stl_pkg::ST_MUL_GL: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_GL;
         end
         stl_pkg::ST_GR_ROM: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_GR;
            ctrl.load_sine = 1'b1;
         end
         stl_pkg::ST_MUL_LFO: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_LFO;
            ctrl.load_gl   = 1'b1;
         end
         stl_pkg::ST_LOAD_GR: begin
            ctrl.load_gr = 1'b1;
         end
         stl_pkg::ST_MUL_DEP: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_DEP;
         end
         stl_pkg::ST_WAIT_DEP: begin
            ctrl.idle = 1'b0;
         end
         stl_pkg::ST_MUL_OL: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_OL;
            ctrl.load_gain = 1'b1;
         end
         stl_pkg::ST_MUL_OR: begin
            ctrl.mul_issue = 1'b1;
            ctrl.mul_sel   = stl_pkg::MSEL_OR;
         end
         stl_pkg::ST_OUT_L: begin
            ctrl.load_left = 1'b1;
         end
         stl_pkg::ST_OUT_R: begin
            ctrl.load_rsp = out_free;
         end
         default: begin
            ctrl.idle = 1'b0;
         end
      endcase
   end

endmodule

[hw/rtl/stl_checker.sv]
// ----------------------------------------------------------------------------
// Stereo tremolo port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_tremolo_lfo_assert.svh"

module stl_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  stl_pkg::rsp_type                    rsp_data
);

   // A stalled result keeps its valid and its payload.
   `STL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // After an input transfer the block is busy on that sample.
   `STL_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready)

   // The tremolo gain never exceeds unity.
   `STL_ASSERT(a_gain_range, rsp_valid |-> rsp_data.mod_gain <= 16'd32768)

endmodule

bind stereo_tremolo_lfo stl_checker u_stl_checker (.*);
